FILE: src/rpd_pkg.sv
// Shared types and constants for the PackBits-style run-length decoder.
// Used by the channel interfaces, the controller, the datapath and the checker.
package rpd_pkg;

   // Number of byte lanes carried by one decoded transaction on the result port.
   localparam int unsigned NUM_LANES = 4;
   // Requested lanes per result word; the result port carries four lanes.
   localparam int unsigned OUT_LANES = 4;
   // Lanes actually filled per full result word, limited to 1..NUM_LANES.
   localparam int unsigned LANES_USED =
      (OUT_LANES < 1) ? 1 : ((OUT_LANES > NUM_LANES) ? NUM_LANES : OUT_LANES);

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 3;

   // A header byte at or above this value opens a literal group.
   localparam logic [BYTE_W-1:0] HDR_SPLIT = 8'd128;

   localparam logic [COUNT_W-1:0] LANES_USED_C = COUNT_W'(LANES_USED);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_header;   // decode a header byte into the remaining count
      logic load_literal;  // pass one literal byte to the result register
      logic emit_word;     // emit one packed word of the current run
      logic use_input;     // the run byte comes from the input this cycle
   } rpd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;      // result register can take a word this cycle
      logic hdr_is_run;    // input byte, read as a header, announces a run
      logic rem_le_one;    // at most one literal byte left
      logic rem_le_lanes;  // the rest of the run fits in one word
   } rpd_sts_type;

endpackage

FILE: src/rpd_if.sv
// Handshake channel interfaces for the run-length decoder: the encoded byte
// request channel and the decoded word response channel. Depends on rpd_pkg.
interface rpd_req_if;
   logic                         valid;
   logic                         ready;
   logic [rpd_pkg::BYTE_W-1:0]   code_byte;

   modport source (output valid, output code_byte, input ready);
   modport sink   (input valid, input code_byte, output ready);
endinterface

interface rpd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rpd_pkg::BYTE_W-1:0]   byte_lane0;
   logic [rpd_pkg::BYTE_W-1:0]   byte_lane1;
   logic [rpd_pkg::BYTE_W-1:0]   byte_lane2;
   logic [rpd_pkg::BYTE_W-1:0]   byte_lane3;
   logic [rpd_pkg::COUNT_W-1:0]  lane_count;
   logic                         final_of_burst;

   modport source (output valid, output byte_lane0, output byte_lane1,
                   output byte_lane2, output byte_lane3, output lane_count,
                   output final_of_burst, input ready);
   modport sink   (input valid, input byte_lane0, input byte_lane1,
                   input byte_lane2, input byte_lane3, input lane_count,
                   input final_of_burst, output ready);
endinterface

FILE: src/rle_packbits_decoder_unit.sv
// Top level of the PackBits-style run-length decoder.
// Depends on rpd_pkg, rpd_req_if, rpd_rsp_if, rpd_ctrl and rpd_datapath.
//
// The decoder takes one encoded byte per request transaction. A header byte
// below 128 announces a run of header+1 copies of the next byte; a header of
// 128 or more announces header-127 literal bytes that follow. Headers produce
// no response. Each literal byte produces one response with one valid lane.
// A run byte produces ceil(length/4) responses, all with four lanes except
// possibly the last, which alone carries final_of_burst. Lanes beyond
// lane_count read as zero. Header bytes are taken at one per cycle, literal
// and run bytes at one per cycle while the result register can take a word.
// After a run byte the request channel is held while the single result
// register issues the rest of the run, and while the response side stalls. If
// the stream stops in a group, the decoder waits in that phase for more bytes.
module rle_packbits_decoder_unit (
   input  logic      clock,
   input  logic      reset,
   rpd_req_if.sink   req_chan,
   rpd_rsp_if.source rsp_chan
);

   rpd_pkg::rpd_cmd_type            cmd;
   rpd_pkg::rpd_sts_type            sts;
   logic [rpd_pkg::BYTE_W-1:0]      lanes [rpd_pkg::NUM_LANES];

   // Phase controller.
   rpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Count, run byte and result register.
   rpd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .code_byte      (req_chan.code_byte),
      .rsp_ready      (rsp_chan.ready),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_chan.valid),
      .rsp_lane       (lanes),
      .rsp_lane_count (rsp_chan.lane_count),
      .rsp_final      (rsp_chan.final_of_burst)
   );

   // Spread the lanes over the response payload.
   assign rsp_chan.byte_lane0 = lanes[0];
   assign rsp_chan.byte_lane1 = lanes[1];
   assign rsp_chan.byte_lane2 = lanes[2];
   assign rsp_chan.byte_lane3 = lanes[3];

endmodule

FILE: src/rpd_ctrl.sv
// Controller of the run-length decoder: tracks the stream phase, drives the
// request handshake and issues commands to the datapath. Depends on rpd_pkg.
module rpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rpd_pkg::rpd_sts_type sts,
   output rpd_pkg::rpd_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_HEADER,
      ST_LITERAL,
      ST_RUN,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_accept;

   // Headers are taken at any time; payload bytes need room in the result register.
   always_comb begin
      unique case (state_ff)
         ST_HEADER:  req_ready = 1'b1;
         ST_LITERAL: req_ready = sts.out_free;
         ST_RUN:     req_ready = sts.out_free;
         ST_EMIT:    req_ready = 1'b0;
         default:    req_ready = 1'b0;
      endcase
   end

   assign req_accept = req_valid && req_ready;

   // Commands to the datapath.
   always_comb begin
      cmd.load_header  = req_accept && (state_ff == ST_HEADER);
      cmd.load_literal = req_accept && (state_ff == ST_LITERAL);
      cmd.use_input    = (state_ff == ST_RUN);
      cmd.emit_word    = (req_accept && (state_ff == ST_RUN)) ||
                         ((state_ff == ST_EMIT) && sts.out_free);
   end

   // Next phase.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_HEADER: begin
            if (req_accept) begin
               state_in = sts.hdr_is_run ? ST_RUN : ST_LITERAL;
            end
         end
         ST_LITERAL: begin
            if (req_accept && sts.rem_le_one) begin
               state_in = ST_HEADER;
            end
         end
         ST_RUN: begin
            if (req_accept) begin
               state_in = sts.rem_le_lanes ? ST_HEADER : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free && sts.rem_le_lanes) begin
               state_in = ST_HEADER;
            end
         end
         default: state_in = ST_HEADER;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HEADER;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/rpd_datapath.sv
// Datapath of the run-length decoder: remaining count, held run byte and the
// result register with its lane packing. Depends on rpd_pkg.
module rpd_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rpd_pkg::BYTE_W-1:0]    code_byte,
   input  logic                          rsp_ready,
   input  rpd_pkg::rpd_cmd_type          cmd,
   output rpd_pkg::rpd_sts_type          sts,
   output logic                          rsp_valid,
   output logic [rpd_pkg::BYTE_W-1:0]    rsp_lane [rpd_pkg::NUM_LANES],
   output logic [rpd_pkg::COUNT_W-1:0]   rsp_lane_count,
   output logic                          rsp_final
);

   localparam int unsigned BW = rpd_pkg::BYTE_W;
   localparam int unsigned CW = rpd_pkg::COUNT_W;

   logic [BW-1:0] remaining_ff;
   logic [BW-1:0] remaining_in;
   logic [BW-1:0] run_byte_ff;
   logic [BW-1:0] run_byte_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic [BW-1:0] out_lane_ff [rpd_pkg::NUM_LANES];
   logic [BW-1:0] out_lane_in [rpd_pkg::NUM_LANES];
   logic [CW-1:0] out_count_ff;
   logic [CW-1:0] out_count_in;
   logic          out_final_ff;
   logic          out_final_in;

   logic          load_word;
   logic [BW-1:0] word_byte;
   logic [CW-1:0] word_count;
   logic          word_final;

   // Status toward the controller.
   always_comb begin
      sts.out_free     = !out_valid_ff || rsp_ready;
      sts.hdr_is_run   = (code_byte < rpd_pkg::HDR_SPLIT);
      sts.rem_le_one   = (remaining_ff <= BW'(1));
      sts.rem_le_lanes = (remaining_ff <= BW'(rpd_pkg::LANES_USED_C));
   end

   // Pick the byte, count and end mark of the word to load.
   always_comb begin
      load_word  = cmd.load_literal || cmd.emit_word;
      word_byte  = (cmd.load_literal || cmd.use_input) ? code_byte : run_byte_ff;
      if (cmd.load_literal) begin
         word_count = CW'(1);
         word_final = 1'b1;
      end else if (sts.rem_le_lanes) begin
         word_count = remaining_ff[CW-1:0];
         word_final = 1'b1;
      end else begin
         word_count = rpd_pkg::LANES_USED_C;
         word_final = 1'b0;
      end
   end

   // Remaining count and held run byte.
   always_comb begin
      remaining_in = remaining_ff;
      run_byte_in  = run_byte_ff;
      if (cmd.load_header) begin
         if (sts.hdr_is_run) begin
            remaining_in = code_byte + BW'(1);
         end else begin
            remaining_in = code_byte - (rpd_pkg::HDR_SPLIT - BW'(1));
         end
      end else if (cmd.load_literal) begin
         remaining_in = remaining_ff - BW'(1);
      end else if (cmd.emit_word) begin
         remaining_in = remaining_ff - BW'(word_count);
      end
      if (cmd.emit_word && cmd.use_input) begin
         run_byte_in = code_byte;
      end
   end

   // Result register: load a packed word or drop the one just taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_count_in = out_count_ff;
      out_final_in = out_final_ff;
      for (int j = 0; j < rpd_pkg::NUM_LANES; j++) begin
         out_lane_in[j] = out_lane_ff[j];
      end
      if (load_word) begin
         out_valid_in = 1'b1;
         out_count_in = word_count;
         out_final_in = word_final;
         for (int j = 0; j < rpd_pkg::NUM_LANES; j++) begin
            out_lane_in[j] = (CW'(j) < word_count) ? word_byte : '0;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         remaining_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         remaining_ff <= remaining_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      run_byte_ff  <= run_byte_in;
      out_count_ff <= out_count_in;
      out_final_ff <= out_final_in;
      for (int j = 0; j < rpd_pkg::NUM_LANES; j++) begin
         out_lane_ff[j] <= out_lane_in[j];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_lane       = out_lane_ff;
   assign rsp_lane_count = out_count_ff;
   assign rsp_final      = out_final_ff;

endmodule

FILE: src/rpd_checker.sv
// Port-level checker for the run-length decoder, bound to the top level.
// Depends on rpd_pkg and on the ports of rle_packbits_decoder_unit.
module rpd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rpd_pkg::BYTE_W-1:0]   lane0,
   input logic [rpd_pkg::BYTE_W-1:0]   lane1,
   input logic [rpd_pkg::BYTE_W-1:0]   lane2,
   input logic [rpd_pkg::BYTE_W-1:0]   lane3,
   input logic [rpd_pkg::COUNT_W-1:0]  lane_count,
   input logic                         final_of_burst
);

   // A response never carries an empty or oversized word.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (lane_count != '0) &&
                    (lane_count <= rpd_pkg::LANES_USED_C))
      else $error("lane_count out of range");

   // Only the last word of a burst may be partly filled.
   a_full_unless_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !final_of_burst |-> lane_count == rpd_pkg::LANES_USED_C)
      else $error("non-final word not full");

   // A single-byte word leaves the other lanes at zero.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (lane_count == 3'd1) |->
         (lane1 == '0) && (lane2 == '0) && (lane3 == '0))
      else $error("unused lane not zero");

   // In a run word, lane1 repeats the byte of lane0.
   a_lanes_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (lane_count > 3'd1) |-> lane1 == lane0)
      else $error("run lanes differ");

   // A stalled response stays valid and holds lane0, its lane count and end mark.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(lane0) &&
         $stable(lane_count) && $stable(final_of_burst))
      else $error("stalled response changed");

endmodule

bind rle_packbits_decoder_unit rpd_checker u_rpd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .lane0          (rsp_chan.byte_lane0),
   .lane1          (rsp_chan.byte_lane1),
   .lane2          (rsp_chan.byte_lane2),
   .lane3          (rsp_chan.byte_lane3),
   .lane_count     (rsp_chan.lane_count),
   .final_of_burst (rsp_chan.final_of_burst)
);
